/* rtl/core/swlru_pkg.sv */
// shared constants, codes and types for the size-weighted lru cache
// no dependencies
`default_nettype none

package swlru_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int SIZE_BITS_DEF = 32;
    localparam int KEY_W         = 64;
    localparam int STAMP_W       = 64;
    localparam int CAP_RESET     = 65536;

    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_EXISTS = 2'd2;
    // command code that the block ignores
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_EVICTED = 3'd1;
    localparam logic [2:0] ST_TOO_BIG = 3'd2;
    localparam logic [2:0] ST_HIT     = 3'd3;
    localparam logic [2:0] ST_MISS    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    typedef struct packed {
        logic match_hit;
        logic lru_hit;
        logic free_hit;
    } scan_flags_t;

endpackage

`default_nettype wire

/* rtl/core/size_weighted_lru_cache_top.sv */
// size-weighted lru cache, top level: command sequencer and output register
// uses swlru_pkg, swlru_slot_mem, swlru_scan
// one pass: a scan over every slot, then a decide step; after the idle accept
// step a get/exists takes one pass, a put
// one pass more per dropped or evicted entry; decide waits while the result
// register is full; one item in flight at a time
// reset (aresetn low, synchronous) empties all slots, clears the byte count
// and loads capacity 65536; no clearing pass is needed
`default_nettype none

module size_weighted_lru_cache_top
    import swlru_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    // config: capacity_bytes
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [31:0]  cfg_data,
    // input beats
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [95:0]  s_tdata,   // key [63:0], entry_bytes [95:64]
    input  wire  [1:0]   s_tuser,   // cmd [1:0]
    // result beats
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [95:0]  m_tdata,   // key_out [63:0], size_out [95:64]
    output logic [2:0]   m_tuser,   // status [2:0]
    output logic         m_tlast
);

    localparam int IW    = $clog2(SLOTS);
    localparam int WORD  = KEY_W + SIZE_BITS + STAMP_W;

    // control state
    state_t               state_reg, state_next;
    logic [IW:0]          scan_cnt_reg;
    logic                 pipe_vld_reg;
    logic [IW-1:0]        pipe_idx_reg;
    logic [SLOTS-1:0]     slot_valid_reg;
    logic [SIZE_BITS-1:0] used_reg;
    logic [SIZE_BITS-1:0] cap_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    logic                 m_vld_reg;

    // current item
    logic [1:0]           cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [SIZE_BITS-1:0] sz_reg;

    // result register
    logic [95:0]          m_data_reg;
    logic [2:0]           m_user_reg;
    logic                 m_last_reg;

    // store ports
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [WORD-1:0]      mem_wdata;
    logic                 mem_re;
    logic [WORD-1:0]      mem_rdata;

    // scan results
    scan_flags_t          flags;
    logic [IW-1:0]        match_idx, lru_idx, free_idx;
    logic [SIZE_BITS-1:0] match_bytes, lru_bytes;
    logic [KEY_W-1:0]     lru_key;

    logic                 in_beat, out_free, scan_clear;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !m_vld_reg || m_tready;
    assign mem_re    = (state_reg == S_SCAN) && (scan_cnt_reg < (IW+1)'(SLOTS));
    // accumulator restarts only when a pass begins, so flags hold through decide stalls
    assign scan_clear = (state_reg != S_SCAN) && (state_next == S_SCAN);

    swlru_slot_mem #(.SLOTS(SLOTS), .WIDTH(WORD)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (scan_cnt_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    swlru_scan #(.SLOTS(SLOTS), .SIZE_BITS(SIZE_BITS)) u_scan (
        .aclk        (aclk),
        .clear       (scan_clear),
        .in_vld      (pipe_vld_reg),
        .in_idx      (pipe_idx_reg),
        .in_slot_vld (slot_valid_reg[pipe_idx_reg]),
        .in_key      (mem_rdata[KEY_W-1:0]),
        .in_bytes    (mem_rdata[KEY_W +: SIZE_BITS]),
        .in_stamp    (mem_rdata[WORD-1 -: STAMP_W]),
        .search_key  (key_reg),
        .flags       (flags),
        .match_idx   (match_idx),
        .match_bytes (match_bytes),
        .lru_idx     (lru_idx),
        .lru_key     (lru_key),
        .lru_bytes   (lru_bytes),
        .free_idx    (free_idx)
    );

    // decision after a full pass; every action waits for a free result register
    logic                 emit;
    logic [2:0]           emit_status;
    logic [KEY_W-1:0]     emit_key;
    logic [SIZE_BITS-1:0] emit_size;
    logic                 emit_last;
    logic                 clr_slot, set_slot;
    logic [IW-1:0]        slot_idx;
    logic [SIZE_BITS-1:0] used_next;
    logic                 stamp_inc;

    always_comb begin
        state_next  = state_reg;
        emit        = 1'b0;
        emit_status = ST_STORED;
        emit_key    = key_reg;
        emit_size   = '0;
        emit_last   = 1'b1;
        clr_slot    = 1'b0;
        set_slot    = 1'b0;
        slot_idx    = free_idx;
        used_next   = used_reg;
        stamp_inc   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = free_idx;
        mem_wdata   = {stamp_reg, sz_reg, key_reg};
        case (state_reg)
            S_IDLE: begin
                if (in_beat && s_tuser != CMD_NONE) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (pipe_vld_reg && pipe_idx_reg == IW'(SLOTS - 1)) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    if (cmd_reg != CMD_PUT) begin
                        // get or exists
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (flags.match_hit) begin
                            emit_status = ST_HIT;
                            emit_size   = match_bytes;
                            if (cmd_reg == CMD_GET) begin
                                mem_we    = 1'b1;
                                mem_waddr = match_idx;
                                mem_wdata = {stamp_reg, match_bytes, key_reg};
                                stamp_inc = 1'b1;
                            end
                        end else begin
                            emit_status = ST_MISS;
                        end
                    end else if (sz_reg > cap_reg) begin
                        emit        = 1'b1;
                        emit_status = ST_TOO_BIG;
                        state_next  = S_IDLE;
                    end else if (flags.match_hit) begin
                        // same key already held: drop it silently and rescan
                        clr_slot   = 1'b1;
                        slot_idx   = match_idx;
                        used_next  = used_reg - match_bytes;
                        state_next = S_SCAN;
                    end else if (flags.lru_hit &&
                                 (used_reg > cap_reg - sz_reg || !flags.free_hit)) begin
                        // evict the least recent entry, then rescan
                        emit        = 1'b1;
                        emit_status = ST_EVICTED;
                        emit_key    = lru_key;
                        emit_size   = lru_bytes;
                        emit_last   = 1'b0;
                        clr_slot    = 1'b1;
                        slot_idx    = lru_idx;
                        used_next   = used_reg - lru_bytes;
                        state_next  = S_SCAN;
                    end else begin
                        // insert as most recent
                        emit       = 1'b1;
                        set_slot   = 1'b1;
                        mem_we     = 1'b1;
                        used_next  = used_reg + sz_reg;
                        stamp_inc  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            pipe_vld_reg   <= 1'b0;
            slot_valid_reg <= '0;
            used_reg       <= '0;
            cap_reg        <= SIZE_BITS'(CAP_RESET);
            stamp_reg      <= '0;
            m_vld_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pipe_vld_reg <= mem_re;
            if (cfg_valid) begin
                cap_reg <= SIZE_BITS'(cfg_data);
            end
            if (state_reg == S_SCAN) begin
                if (mem_re) begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end else begin
                scan_cnt_reg <= '0;
            end
            if (clr_slot) begin
                slot_valid_reg[slot_idx] <= 1'b0;
            end
            if (set_slot) begin
                slot_valid_reg[slot_idx] <= 1'b1;
            end
            used_reg <= used_next;
            if (stamp_inc) begin
                stamp_reg <= stamp_reg + 1'b1;
            end
            if (emit) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pipe_idx_reg <= scan_cnt_reg[IW-1:0];
        if (in_beat) begin
            cmd_reg <= s_tuser;
            key_reg <= s_tdata[63:0];
            sz_reg  <= SIZE_BITS'(s_tdata[95:64]);
        end
        if (emit) begin
            m_data_reg <= {32'(emit_size), emit_key};
            m_user_reg <= emit_status;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

/* rtl/core/swlru_slot_mem.sv */
// slot store: key, size and recency stamp of every slot
// one write port, one registered read port; uses swlru_pkg
`default_nettype none

module swlru_slot_mem
    import swlru_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int WIDTH = 160
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire [$clog2(SLOTS)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire                       re,
    input  wire [$clog2(SLOTS)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/swlru_scan.sv */
// scan accumulator: key match, least recent slot and lowest free slot
// fed one slot per cycle from the slot store; uses swlru_pkg
`default_nettype none

module swlru_scan
    import swlru_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire                         aclk,
    input  wire                         clear,
    input  wire                         in_vld,
    input  wire [$clog2(SLOTS)-1:0]     in_idx,
    input  wire                         in_slot_vld,
    input  wire [KEY_W-1:0]             in_key,
    input  wire [SIZE_BITS-1:0]         in_bytes,
    input  wire [STAMP_W-1:0]           in_stamp,
    input  wire [KEY_W-1:0]             search_key,
    output scan_flags_t                 flags,
    output logic [$clog2(SLOTS)-1:0]    match_idx,
    output logic [SIZE_BITS-1:0]        match_bytes,
    output logic [$clog2(SLOTS)-1:0]    lru_idx,
    output logic [KEY_W-1:0]            lru_key,
    output logic [SIZE_BITS-1:0]        lru_bytes,
    output logic [$clog2(SLOTS)-1:0]    free_idx
);

    localparam int IW = $clog2(SLOTS);

    scan_flags_t        flags_reg;
    logic [IW-1:0]      match_idx_reg;
    logic [SIZE_BITS-1:0] match_bytes_reg;
    logic [IW-1:0]      lru_idx_reg;
    logic [KEY_W-1:0]   lru_key_reg;
    logic [SIZE_BITS-1:0] lru_bytes_reg;
    logic [STAMP_W-1:0] lru_stamp_reg;
    logic [IW-1:0]      free_idx_reg;

    always_ff @(posedge aclk) begin
        if (clear) begin
            flags_reg <= '0;
        end else if (in_vld) begin
            if (in_slot_vld && in_key == search_key) begin
                flags_reg.match_hit <= 1'b1;
                match_idx_reg       <= in_idx;
                match_bytes_reg     <= in_bytes;
            end
            if (in_slot_vld && (!flags_reg.lru_hit || in_stamp < lru_stamp_reg)) begin
                flags_reg.lru_hit <= 1'b1;
                lru_idx_reg       <= in_idx;
                lru_key_reg       <= in_key;
                lru_bytes_reg     <= in_bytes;
                lru_stamp_reg     <= in_stamp;
            end
            if (!in_slot_vld && !flags_reg.free_hit) begin
                flags_reg.free_hit <= 1'b1;
                free_idx_reg       <= in_idx;
            end
        end
    end

    assign flags       = flags_reg;
    assign match_idx   = match_idx_reg;
    assign match_bytes = match_bytes_reg;
    assign lru_idx     = lru_idx_reg;
    assign lru_key     = lru_key_reg;
    assign lru_bytes   = lru_bytes_reg;
    assign free_idx    = free_idx_reg;

endmodule

`default_nettype wire
